>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of the set union/intersection block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SUI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SUI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> hdl/sui_pkg.sv
// Shared types and constants of the set union/intersection block.
package sui_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int VAL_W     = 32;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_RD,
        ST_SORT_FIRST,
        ST_SORT_SCAN,
        ST_SORT_WB,
        ST_UNI_RD,
        ST_UNI_GET,
        ST_BIG_RD,
        ST_BIG_GET,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_PUSH,
        ST_FINAL
    } state_t;

    // Result of the shared comparator
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage

>>> hdl/set_union_intersection.sv
// Top level of the set union/intersection block.
//
//  channel   | handshake              | beat
//  ----------+------------------------+--------------------------------------
//  input     | valid / stall          | which_set, value, last
//  result    | valid_res / stall_res  | value_res, has_value, overflow, last_res
//  config    | cfg_we                 | cfg_wdata (mode: 0 intersect, 1 union)
//
// Loading takes one beat per cycle; after a beat with last, stall stays high for the run.
// The smaller set (m entries) is sorted; each larger-set element is then searched for with
// p <= log2(m)+1 probes. A union sends each sorted entry first, and a closing beat ends the
// run. A stalled result holds and the sequencer waits at its next result; the next run's
// beats are taken while the final result still waits. Reset clears counts, flags, mode and
// the other control registers, but not the payload registers.
module set_union_intersection #(
    parameter int DEPTH = sui_pkg::DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic                             cfg_wdata,
    input  logic                             valid,
    output logic                             stall,
    input  logic                             which_set,
    input  logic signed [sui_pkg::VAL_W-1:0] value,
    input  logic                             last,
    output logic                             valid_res,
    input  logic                             stall_res,
    output logic signed [sui_pkg::VAL_W-1:0] value_res,
    output logic                             has_value,
    output logic                             overflow,
    output logic                             last_res
);
    import sui_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                    we0, we1;
    logic [AW-1:0]           waddr0, waddr1, raddr0, raddr1;
    logic [VAL_W-1:0]        wdata0, wdata1, rdata0, rdata1;
    logic signed [VAL_W-1:0] cmp_a, cmp_b;
    cmp_res_t                cmp_res;

    // sequencer
    sui_seq #(.DEPTH(DEPTH)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .valid     (valid),
        .stall     (stall),
        .which_set (which_set),
        .value     (value),
        .last      (last),
        .valid_res (valid_res),
        .stall_res (stall_res),
        .value_res (value_res),
        .has_value (has_value),
        .overflow  (overflow),
        .last_res  (last_res),
        .we0       (we0),
        .waddr0    (waddr0),
        .wdata0    (wdata0),
        .raddr0    (raddr0),
        .rdata0    (rdata0),
        .we1       (we1),
        .waddr1    (waddr1),
        .wdata1    (wdata1),
        .raddr1    (raddr1),
        .rdata1    (rdata1),
        .cmp_a     (cmp_a),
        .cmp_b     (cmp_b),
        .cmp_res   (cmp_res)
    );

    // first and second stores
    sui_mem #(.DEPTH(DEPTH)) u_mem_first (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr0),
        .wdata (wdata0),
        .raddr (raddr0),
        .rdata (rdata0)
    );

    sui_mem #(.DEPTH(DEPTH)) u_mem_second (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr1),
        .wdata (wdata1),
        .raddr (raddr1),
        .rdata (rdata1)
    );

    // shared comparator
    sui_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

endmodule

>>> hdl/sui_cmp.sv
// Shared signed comparator used by both the sort and the binary search.
module sui_cmp (
    input  logic signed [sui_pkg::VAL_W-1:0] a,
    input  logic signed [sui_pkg::VAL_W-1:0] b,
    output sui_pkg::cmp_res_t                res
);
    import sui_pkg::*;

    // a < b in two's complement, and equality
    assign res.lt = (a < b);
    assign res.eq = (a == b);

endmodule

>>> hdl/sui_mem.sv
// One element store: single write port, single registered read port.
module sui_mem #(
    parameter int DEPTH = sui_pkg::DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [$clog2(DEPTH)-1:0]    waddr,
    input  logic [sui_pkg::VAL_W-1:0]   wdata,
    input  logic [$clog2(DEPTH)-1:0]    raddr,
    output logic [sui_pkg::VAL_W-1:0]   rdata
);
    import sui_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/sui_seq.sv
// Sequencer: loading, in-place selection sort, binary search and result output.
module sui_seq #(
    parameter int DEPTH = sui_pkg::DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_we,
    input  logic                             cfg_wdata,
    // input channel
    input  logic                             valid,
    output logic                             stall,
    input  logic                             which_set,
    input  logic signed [sui_pkg::VAL_W-1:0] value,
    input  logic                             last,
    // result channel
    output logic                             valid_res,
    input  logic                             stall_res,
    output logic signed [sui_pkg::VAL_W-1:0] value_res,
    output logic                             has_value,
    output logic                             overflow,
    output logic                             last_res,
    // first store
    output logic                             we0,
    output logic [$clog2(DEPTH)-1:0]         waddr0,
    output logic [sui_pkg::VAL_W-1:0]        wdata0,
    output logic [$clog2(DEPTH)-1:0]         raddr0,
    input  logic [sui_pkg::VAL_W-1:0]        rdata0,
    // second store
    output logic                             we1,
    output logic [$clog2(DEPTH)-1:0]         waddr1,
    output logic [sui_pkg::VAL_W-1:0]        wdata1,
    output logic [$clog2(DEPTH)-1:0]         raddr1,
    input  logic [sui_pkg::VAL_W-1:0]        rdata1,
    // shared comparator
    output logic signed [sui_pkg::VAL_W-1:0] cmp_a,
    output logic signed [sui_pkg::VAL_W-1:0] cmp_b,
    input  sui_pkg::cmp_res_t                cmp_res
);
    import sui_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // control state
    state_t          state_reg, state_next;
    state_t          ret_reg, ret_next;
    logic            mode_reg;
    logic [CW-1:0]   fcnt_reg, fcnt_next;
    logic [CW-1:0]   scnt_reg, scnt_next;
    logic            dropped_reg, dropped_next;
    logic            small_sel_reg, small_sel_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   j_reg, j_next;
    logic [CW-1:0]   lo_reg, lo_next;
    logic [CW-1:0]   hi_reg, hi_next;
    logic            pend_valid_reg, pend_valid_next;
    logic            ovalid_reg, ovalid_next;

    // payload
    logic [VAL_W-1:0] cur_reg, cur_next;
    logic [VAL_W-1:0] x_reg, x_next;
    logic [VAL_W-1:0] cand_reg, cand_next;
    logic [VAL_W-1:0] pend_reg, pend_next;
    logic [VAL_W-1:0] oval_reg;
    logic             ohas_reg;
    logic             oovf_reg;
    logic             olast_reg;

    // output register load request
    logic             out_load;
    logic [VAL_W-1:0] out_val_d;
    logic             out_has_d;
    logic             out_last_d;
    logic             out_free;

    // small-set memory view
    logic             s_we;
    logic [AW-1:0]    s_waddr;
    logic [VAL_W-1:0] s_wdata;
    logic [AW-1:0]    s_raddr;
    logic [AW-1:0]    b_raddr;
    logic [VAL_W-1:0] s_rdata;
    logic [VAL_W-1:0] b_rdata;

    logic [CW-1:0]    m_cnt;
    logic [CW-1:0]    n_cnt;
    logic [CW-1:0]    mid;
    logic [CW-1:0]    i_inc;
    logic [CW-1:0]    j_inc;
    logic             accept;

    assign m_cnt   = small_sel_reg ? scnt_reg : fcnt_reg;
    assign n_cnt   = small_sel_reg ? fcnt_reg : scnt_reg;
    assign s_rdata = small_sel_reg ? rdata1 : rdata0;
    assign b_rdata = small_sel_reg ? rdata0 : rdata1;
    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign i_inc   = i_reg + CW'(1);
    assign j_inc   = j_reg + CW'(1);

    assign stall    = (state_reg != ST_LOAD);
    assign accept   = valid && !stall;
    assign out_free = !ovalid_reg || !stall_res;

    // comparator operands: sort compares a[j] with the held minimum,
    // search compares the key with the probed entry
    assign cmp_a = (state_reg == ST_SORT_SCAN) ? s_rdata : x_reg;
    assign cmp_b = (state_reg == ST_SORT_SCAN) ? cur_reg : s_rdata;

    // route small/big views onto the two stores
    always_comb
    begin
        we0    = 1'b0;
        waddr0 = fcnt_reg[AW-1:0];
        wdata0 = value;
        we1    = 1'b0;
        waddr1 = scnt_reg[AW-1:0];
        wdata1 = value;
        raddr0 = small_sel_reg ? b_raddr : s_raddr;
        raddr1 = small_sel_reg ? s_raddr : b_raddr;
        if (state_reg == ST_LOAD)
        begin
            we0 = accept && !which_set && (fcnt_reg < CW'(DEPTH));
            we1 = accept && which_set && (scnt_reg < CW'(DEPTH));
        end
        else if (small_sel_reg)
        begin
            we1    = s_we;
            waddr1 = s_waddr;
            wdata1 = s_wdata;
        end
        else
        begin
            we0    = s_we;
            waddr0 = s_waddr;
            wdata0 = s_wdata;
        end
    end

    // next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        fcnt_next       = fcnt_reg;
        scnt_next       = scnt_reg;
        dropped_next    = dropped_reg;
        small_sel_next  = small_sel_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        pend_valid_next = pend_valid_reg;
        cur_next        = cur_reg;
        x_next          = x_reg;
        cand_next       = cand_reg;
        pend_next       = pend_reg;
        s_we            = 1'b0;
        s_waddr         = i_reg[AW-1:0];
        s_wdata         = cur_reg;
        s_raddr         = i_reg[AW-1:0];
        b_raddr         = j_reg[AW-1:0];
        out_load        = 1'b0;
        out_val_d       = pend_reg;
        out_has_d       = 1'b1;
        out_last_d      = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (which_set)
                    begin
                        if (scnt_reg < CW'(DEPTH))
                        begin
                            scnt_next = scnt_reg + CW'(1);
                        end
                        else
                        begin
                            dropped_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (fcnt_reg < CW'(DEPTH))
                        begin
                            fcnt_next = fcnt_reg + CW'(1);
                        end
                        else
                        begin
                            dropped_next = 1'b1;
                        end
                    end
                    if (last)
                    begin
                        // equal sizes: first set is the small one
                        small_sel_next = (fcnt_next > scnt_next);
                        i_next         = '0;
                        state_next     = ST_SORT_RD;
                    end
                end
            end

            // sort: fetch a[i]
            ST_SORT_RD:
            begin
                s_raddr = i_reg[AW-1:0];
                if (i_reg >= m_cnt)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = mode_reg ? ST_UNI_RD : ST_BIG_RD;
                end
                else
                begin
                    state_next = ST_SORT_FIRST;
                end
            end

            // hold a[i], start scanning at i+1
            ST_SORT_FIRST:
            begin
                cur_next = s_rdata;
                j_next   = i_inc;
                s_raddr  = i_inc[AW-1:0];
                state_next = (i_inc < m_cnt) ? ST_SORT_SCAN : ST_SORT_WB;
            end

            // a[j] < held value: swap through the held register
            ST_SORT_SCAN:
            begin
                if (cmp_res.lt)
                begin
                    s_we     = 1'b1;
                    s_waddr  = j_reg[AW-1:0];
                    s_wdata  = cur_reg;
                    cur_next = s_rdata;
                end
                j_next  = j_inc;
                s_raddr = j_inc[AW-1:0];
                if (j_inc >= m_cnt)
                begin
                    state_next = ST_SORT_WB;
                end
            end

            ST_SORT_WB:
            begin
                s_we       = 1'b1;
                s_waddr    = i_reg[AW-1:0];
                s_wdata    = cur_reg;
                i_next     = i_inc;
                state_next = ST_SORT_RD;
            end

            // union: sorted small set first
            ST_UNI_RD:
            begin
                s_raddr = i_reg[AW-1:0];
                state_next = (i_reg >= m_cnt) ? ST_BIG_RD : ST_UNI_GET;
            end

            ST_UNI_GET:
            begin
                cand_next  = s_rdata;
                i_next     = i_inc;
                ret_next   = ST_UNI_RD;
                state_next = ST_PUSH;
            end

            // fetch next large-set element in load order
            ST_BIG_RD:
            begin
                b_raddr = j_reg[AW-1:0];
                state_next = (j_reg >= n_cnt) ? ST_FINAL : ST_BIG_GET;
            end

            ST_BIG_GET:
            begin
                x_next     = b_rdata;
                lo_next    = '0;
                hi_next    = m_cnt;
                j_next     = j_inc;
                state_next = ST_SRCH_RD;
            end

            // binary search over [lo, hi)
            ST_SRCH_RD:
            begin
                s_raddr = mid[AW-1:0];
                if (lo_reg < hi_reg)
                begin
                    state_next = ST_SRCH_CMP;
                end
                else if (mode_reg)
                begin
                    cand_next  = x_reg;
                    ret_next   = ST_BIG_RD;
                    state_next = ST_PUSH;
                end
                else
                begin
                    state_next = ST_BIG_RD;
                end
            end

            ST_SRCH_CMP:
            begin
                if (cmp_res.eq)
                begin
                    if (mode_reg)
                    begin
                        state_next = ST_BIG_RD;
                    end
                    else
                    begin
                        cand_next  = x_reg;
                        ret_next   = ST_BIG_RD;
                        state_next = ST_PUSH;
                    end
                end
                else if (cmp_res.lt)
                begin
                    hi_next    = mid;
                    state_next = ST_SRCH_RD;
                end
                else
                begin
                    lo_next    = mid + CW'(1);
                    state_next = ST_SRCH_RD;
                end
            end

            // one result held back so the final one can carry last_res
            ST_PUSH:
            begin
                if (!pend_valid_reg)
                begin
                    pend_next       = cand_reg;
                    pend_valid_next = 1'b1;
                    state_next      = ret_reg;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    out_val_d  = pend_reg;
                    pend_next  = cand_reg;
                    state_next = ret_reg;
                end
            end

            // closing beat: held result or the empty answer
            ST_FINAL:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_val_d       = pend_valid_reg ? pend_reg : '0;
                    out_has_d       = pend_valid_reg;
                    out_last_d      = 1'b1;
                    pend_valid_next = 1'b0;
                    fcnt_next       = '0;
                    scnt_next       = '0;
                    dropped_next    = 1'b0;
                    state_next      = ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // output valid
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (out_load)
        begin
            ovalid_next = 1'b1;
        end
        else if (!stall_res)
        begin
            ovalid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            ret_reg        <= ST_LOAD;
            mode_reg       <= 1'b0;
            fcnt_reg       <= '0;
            scnt_reg       <= '0;
            dropped_reg    <= 1'b0;
            small_sel_reg  <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            pend_valid_reg <= 1'b0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            fcnt_reg       <= fcnt_next;
            scnt_reg       <= scnt_next;
            dropped_reg    <= dropped_next;
            small_sel_reg  <= small_sel_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            pend_valid_reg <= pend_valid_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        x_reg    <= x_next;
        cand_reg <= cand_next;
        pend_reg <= pend_next;
        if (out_load)
        begin
            oval_reg  <= out_val_d;
            ohas_reg  <= out_has_d;
            oovf_reg  <= dropped_reg;
            olast_reg <= out_last_d;
        end
    end

    assign valid_res = ovalid_reg;
    assign value_res = oval_reg;
    assign has_value = ohas_reg;
    assign overflow  = oovf_reg;
    assign last_res  = olast_reg;

endmodule

>>> hdl/sui_checker.sv
// Port-level checker for the set union/intersection block and its bind.
`include "assert_macros.svh"

module sui_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             valid,
    input logic                             stall,
    input logic                             last,
    input logic                             valid_res,
    input logic                             stall_res,
    input logic signed [sui_pkg::VAL_W-1:0] value_res,
    input logic                             has_value,
    input logic                             overflow,
    input logic                             last_res
);
    import sui_pkg::*;

    // the empty answer is always the single, closing beat
    `SUI_ASSERT_SAME(a_empty_is_last, clk, rst_n, valid_res && !has_value, last_res)

    // a closing input beat starts the run: no input taken next cycle
    `SUI_ASSERT_NEXT(a_last_stalls, clk, rst_n, valid && !stall && last, stall)

    // overflow flag does not change inside a run
    `SUI_ASSERT_NEXT(a_ovf_steady, clk, rst_n, valid_res && !stall_res && !last_res, $stable(overflow))

    // stalled result beat holds
    `SUI_ASSERT_NEXT(a_res_hold, clk, rst_n, valid_res && stall_res, valid_res && $stable(value_res) && $stable(last_res))

endmodule

bind set_union_intersection sui_checker u_sui_checker (.*);
